// File: design/gpic_pkg.sv
// ----------------------------------------------------------------------------
// gpic_pkg
// shared types, codes and constants for the gamepad input conditioner
// ----------------------------------------------------------------------------
package gpic_pkg;

  // event kinds
  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_AXIS   = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_HORIZ_PRI = 3'd0;
  localparam logic [2:0] REG_VERT_PRI  = 3'd1;
  localparam logic [2:0] REG_HORIZ_SEC = 3'd2;
  localparam logic [2:0] REG_VERT_SEC  = 3'd3;
  localparam logic [2:0] REG_DEAD_ZONE = 3'd4;
  localparam logic [2:0] REG_DIR_THR   = 3'd5;
  localparam logic [2:0] REG_AXBTN_THR = 3'd6;
  localparam logic [2:0] REG_INV_VERT  = 3'd7;

  // sizing defaults
  localparam int NUM_BUTTONS_DEF = 32;
  localparam int NUM_AXES_DEF    = 16;

  localparam int          CAL_TICKS = 40;
  localparam logic [15:0] AXIS_MAX  = 16'sd32767;

  // register reset values
  localparam logic [3:0]  HORIZ_PRI_RST = 4'd0;
  localparam logic [3:0]  VERT_PRI_RST  = 4'd1;
  localparam logic [3:0]  HORIZ_SEC_RST = 4'd4;
  localparam logic [3:0]  VERT_SEC_RST  = 4'd5;
  localparam logic [14:0] DEAD_ZONE_RST = 15'd8000;
  localparam logic [14:0] DIR_THR_RST   = 15'd16000;
  localparam logic [14:0] AXBTN_THR_RST = 15'd12000;

  typedef struct packed {
    logic [3:0]  horiz_pri;
    logic [3:0]  vert_pri;
    logic [3:0]  horiz_sec;
    logic [3:0]  vert_sec;
    logic [14:0] dead_zone;
    logic [14:0] dir_thr;
    logic [14:0] axbtn_thr;
    logic        inv_vert;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] horiz_level;
    logic signed [15:0] vert_level;
    logic [3:0]         dir;
    logic [3:0]         axbtn;
  } level_t;

endpackage

// File: design/gpic_axis_lane.sv
// ----------------------------------------------------------------------------
// gpic_axis_lane
// one axis: current position, rest value and clamped relative reading
// ----------------------------------------------------------------------------
module gpic_axis_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,          // axis event for this lane
  input  logic signed [15:0] wr_value,
  input  logic               capture,     // copy position into rest value
  input  logic               calibrated,
  output logic signed [15:0] reading
);

  logic signed [15:0] pos;
  logic signed [15:0] rest;
  logic signed [16:0] diff;
  logic               rest_extreme;

  assign rest_extreme = (rest == gpic_pkg::AXIS_MAX) || (rest == -gpic_pkg::AXIS_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      rest <= '0;
    end else begin
      if (wr) begin
        pos <= wr_value;
        if (calibrated && (wr_value == 16'sd0) && rest_extreme) begin
          rest <= '0;
        end
      end
      if (capture) begin
        rest <= pos;
      end
    end
  end

  // relative to rest once calibrated, clamped to +-32767
  always_comb begin
    diff = {pos[15], pos} - (calibrated ? {rest[15], rest} : 17'sd0);
    if (diff > 17'sd32767) begin
      reading = gpic_pkg::AXIS_MAX;
    end else if (diff < -17'sd32767) begin
      reading = -gpic_pkg::AXIS_MAX;
    end else begin
      reading = diff[15:0];
    end
  end

endmodule

// File: design/gpic_level_eval.sv
// ----------------------------------------------------------------------------
// gpic_level_eval
// picks primary or secondary axis, applies deadzone and direction thresholds
// ----------------------------------------------------------------------------
module gpic_level_eval (
  input  logic signed [15:0] horiz_pri,
  input  logic signed [15:0] horiz_sec,
  input  logic signed [15:0] vert_pri,
  input  logic signed [15:0] vert_sec,
  input  gpic_pkg::cfg_t     cfg,
  output gpic_pkg::level_t   level
);

  logic signed [15:0] h;
  logic signed [15:0] v;
  logic [14:0]        h_mag;
  logic [14:0]        v_mag;
  logic [14:0]        hp_mag;
  logic [14:0]        hs_mag;
  logic [14:0]        vp_mag;
  logic [14:0]        vs_mag;
  logic               v_up;
  logic               v_down;

  // inputs are within +-32767, so magnitude fits in 15 bits
  function automatic logic [14:0] magnitude(input logic signed [15:0] x);
    logic signed [15:0] a;
    a = x[15] ? -x : x;
    return a[14:0];
  endfunction

  always_comb begin
    hp_mag = magnitude(horiz_pri);
    hs_mag = magnitude(horiz_sec);
    vp_mag = magnitude(vert_pri);
    vs_mag = magnitude(vert_sec);

    // secondary wins only on strictly larger magnitude
    h     = (hs_mag > hp_mag) ? horiz_sec : horiz_pri;
    h_mag = (hs_mag > hp_mag) ? hs_mag : hp_mag;
    v     = (vs_mag > vp_mag) ? vert_sec : vert_pri;
    v_mag = (vs_mag > vp_mag) ? vs_mag : vp_mag;

    level.horiz_level = (h_mag < cfg.dead_zone) ? 16'sd0 : h;
    level.vert_level  = (v_mag < cfg.dead_zone) ? 16'sd0 : v;
    if (!cfg.inv_vert) begin
      level.vert_level = -level.vert_level;
    end

    v_up   = !v[15] && (v_mag > cfg.dir_thr);
    v_down =  v[15] && (v_mag > cfg.dir_thr);
    level.dir[0] = cfg.inv_vert ? v_up : v_down;
    level.dir[1] = cfg.inv_vert ? v_down : v_up;
    level.dir[2] =  h[15] && (h_mag > cfg.dir_thr);
    level.dir[3] = !h[15] && (h_mag > cfg.dir_thr);

    // raw vertical sign, no inversion
    level.axbtn[0] = !h[15] && (h_mag > cfg.axbtn_thr);
    level.axbtn[1] =  h[15] && (h_mag > cfg.axbtn_thr);
    level.axbtn[2] = !v[15] && (v_mag > cfg.axbtn_thr);
    level.axbtn[3] =  v[15] && (v_mag > cfg.axbtn_thr);
  end

endmodule

// File: design/gamepad_input_conditioner_core.sv
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_core
// joystick event conditioner: button edges, axis calibration, deadzone, directions
// ----------------------------------------------------------------------------
// datapath: an accepted event is registered in the input register, then evaluated; a
//   frame tick loads the result register, which drives the master side
// throughput: one event per cycle; the input register stalls only while a tick
//   waits behind a result that the downstream side has not taken
// reset: synchronous, active high; clears button, axis and calibration state,
//   the edge history, the pipeline valids and loads the register defaults
module gamepad_input_conditioner_core #(
  parameter int NUM_BUTTONS = gpic_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = gpic_pkg::NUM_AXES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // event stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // event_kind[1:0], event_number[6:2], event_value[22:7]
  // result stream, one per frame tick
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,   // buttons_held[31:0], buttons_pressed[63:32],
                                  // buttons_released[95:64], horizontal_level[111:96],
                                  // vertical_level[127:112], direction_held[131:128],
                                  // direction_pressed[135:132], axis_button_held[139:136],
                                  // axis_button_pressed[143:140], is_calibrated[144]
  // register write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [14:0]  cfg_data
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  gpic_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.horiz_pri <= gpic_pkg::HORIZ_PRI_RST;
      cfg.vert_pri  <= gpic_pkg::VERT_PRI_RST;
      cfg.horiz_sec <= gpic_pkg::HORIZ_SEC_RST;
      cfg.vert_sec  <= gpic_pkg::VERT_SEC_RST;
      cfg.dead_zone <= gpic_pkg::DEAD_ZONE_RST;
      cfg.dir_thr   <= gpic_pkg::DIR_THR_RST;
      cfg.axbtn_thr <= gpic_pkg::AXBTN_THR_RST;
      cfg.inv_vert  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gpic_pkg::REG_HORIZ_PRI: cfg.horiz_pri <= cfg_data[3:0];
        gpic_pkg::REG_VERT_PRI:  cfg.vert_pri  <= cfg_data[3:0];
        gpic_pkg::REG_HORIZ_SEC: cfg.horiz_sec <= cfg_data[3:0];
        gpic_pkg::REG_VERT_SEC:  cfg.vert_sec  <= cfg_data[3:0];
        gpic_pkg::REG_DEAD_ZONE: cfg.dead_zone <= cfg_data;
        gpic_pkg::REG_DIR_THR:   cfg.dir_thr   <= cfg_data;
        gpic_pkg::REG_AXBTN_THR: cfg.axbtn_thr <= cfg_data;
        gpic_pkg::REG_INV_VERT:  cfg.inv_vert  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic               in_valid;
  logic [1:0]         in_kind;
  logic [4:0]         in_number;
  logic signed [15:0] in_value;

  logic out_free;   // result register empty or being drained this cycle
  logic adv;        // registered event is consumed this cycle
  logic adv_tick;

  assign out_free = !m_tvalid || m_tready;
  // only a tick needs the result register
  assign adv      = in_valid && ((in_kind != gpic_pkg::KIND_TICK) || out_free);
  assign adv_tick = adv && (in_kind == gpic_pkg::KIND_TICK);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind   <= s_tdata[1:0];
      in_number <= s_tdata[6:2];
      in_value  <= s_tdata[22:7];
    end
  end

  // --------------------------------------------------------------------------
  // button state
  // --------------------------------------------------------------------------
  logic [NUM_BUTTONS-1:0] button_now;
  logic [NUM_BUTTONS-1:0] button_last;
  logic [NUM_BUTTONS-1:0] button_bit;
  logic                   button_hit;

  assign button_hit = adv && (in_kind == gpic_pkg::KIND_BUTTON)
                      && ({1'b0, in_number} < 6'(NUM_BUTTONS));
  assign button_bit = NUM_BUTTONS'(1) << in_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_now  <= '0;
      button_last <= '0;
    end else begin
      if (button_hit) begin
        if (in_value != 16'sd0) begin
          button_now <= button_now | button_bit;
        end else begin
          button_now <= button_now & ~button_bit;
        end
      end
      if (adv_tick) begin
        button_last <= button_now;
      end
    end
  end

  // --------------------------------------------------------------------------
  // calibration: rest values are captured on the 40th tick
  // --------------------------------------------------------------------------
  logic [5:0] tick_count;
  logic [5:0] tick_count_next;
  logic       calibrated;
  logic       cal_capture;

  assign tick_count_next = tick_count + 6'd1;
  assign cal_capture     = adv_tick && !calibrated && (tick_count_next == 6'(gpic_pkg::CAL_TICKS));

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      calibrated <= 1'b0;
    end else if (adv_tick && !calibrated) begin
      tick_count <= tick_count_next;
      if (cal_capture) begin
        calibrated <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // axis lanes
  // --------------------------------------------------------------------------
  logic signed [15:0] lane_reading [NUM_AXES];
  logic               axis_event;

  assign axis_event = adv && (in_kind == gpic_pkg::KIND_AXIS);

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    gpic_axis_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .wr         (axis_event && (in_number == 5'(i))),
      .wr_value   (in_value),
      .capture    (cal_capture),
      .calibrated (calibrated),
      .reading    (lane_reading[i])
    );
  end

  // selector past the last axis reads zero; right after capture every axis reads zero
  function automatic logic signed [15:0] pick(input logic [3:0] sel,
                                              input logic signed [15:0] rd [NUM_AXES]);
    logic signed [15:0] r;
    r = 16'sd0;
    for (int k = 0; k < NUM_AXES; k++) begin
      if (sel == 4'(k)) begin
        r = rd[k];
      end
    end
    return r;
  endfunction

  logic signed [15:0] horiz_pri;
  logic signed [15:0] horiz_sec;
  logic signed [15:0] vert_pri;
  logic signed [15:0] vert_sec;

  always_comb begin
    if (cal_capture) begin
      horiz_pri = 16'sd0;
      horiz_sec = 16'sd0;
      vert_pri  = 16'sd0;
      vert_sec  = 16'sd0;
    end else begin
      horiz_pri = pick(cfg.horiz_pri, lane_reading);
      horiz_sec = pick(cfg.horiz_sec, lane_reading);
      vert_pri  = pick(cfg.vert_pri, lane_reading);
      vert_sec  = pick(cfg.vert_sec, lane_reading);
    end
  end

  gpic_pkg::level_t level;

  gpic_level_eval u_eval (
    .horiz_pri (horiz_pri),
    .horiz_sec (horiz_sec),
    .vert_pri  (vert_pri),
    .vert_sec  (vert_sec),
    .cfg       (cfg),
    .level     (level)
  );

  // --------------------------------------------------------------------------
  // edge history and result register
  // --------------------------------------------------------------------------
  logic [3:0] dir_last;
  logic [3:0] axbtn_last;

  logic [31:0]        res_held;
  logic [31:0]        res_pressed;
  logic [31:0]        res_released;
  logic signed [15:0] res_horiz;
  logic signed [15:0] res_vert;
  logic [3:0]         res_dir;
  logic [3:0]         res_dir_pressed;
  logic [3:0]         res_axbtn;
  logic [3:0]         res_axbtn_pressed;
  logic               res_cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_last   <= '0;
      axbtn_last <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (adv_tick) begin
        dir_last   <= level.dir;
        axbtn_last <= level.axbtn;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_tick) begin
      res_held          <= 32'(button_now);
      res_pressed       <= 32'(button_now & ~button_last);
      res_released      <= 32'(button_last & ~button_now);
      res_horiz         <= level.horiz_level;
      res_vert          <= level.vert_level;
      res_dir           <= level.dir;
      res_dir_pressed   <= level.dir & ~dir_last;
      res_axbtn         <= level.axbtn;
      res_axbtn_pressed <= level.axbtn & ~axbtn_last;
      res_cal           <= calibrated || cal_capture;
    end
  end

  assign m_tdata = {7'b0, res_cal, res_axbtn_pressed, res_axbtn, res_dir_pressed, res_dir,
                    res_vert, res_horiz, res_released, res_pressed, res_held};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_tick_bound: assert property (@(posedge clk) disable iff (rst)
    tick_count <= 6'(gpic_pkg::CAL_TICKS))
    else $error("tick counter ran past calibration point");

  a_cal_count: assert property (@(posedge clk) disable iff (rst)
    calibrated |-> (tick_count == 6'(gpic_pkg::CAL_TICKS)))
    else $error("calibrated without full tick count");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(adv_tick))
    else $error("result appeared without a tick");

  a_up_down: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res_dir[0] && res_dir[1]))
    else $error("up and down held together");

  a_press_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((res_pressed & ~res_held) == 32'd0))
    else $error("pressed button not held");

endmodule
